// ===== hw/rtl/tab_expander_macros.svh =====
`ifndef TAB_EXPANDER_MACROS_SVH
`define TAB_EXPANDER_MACROS_SVH

// Same-cycle implication, checked on clk with reset masked.
`define TE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tab_expander check failed");

// Next-cycle implication, checked on clk with reset masked.
`define TE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tab_expander check failed");

`endif

// ===== hw/rtl/te_pkg.sv =====
`timescale 1ns / 1ps

package te_pkg;

  localparam int unsigned WIDTH_BITS = 7;
  localparam logic [WIDTH_BITS-1:0] WIDTH_CAP = 7'd64;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STOP_COUNT   = 3'd0,
    REG_STOP_WIDTH_A = 3'd1,
    REG_STOP_WIDTH_B = 3'd2,
    REG_STOP_WIDTH_C = 3'd3,
    REG_STOP_WIDTH_D = 3'd4,
    REG_REPEAT_WIDTH = 3'd5,
    REG_START_COLUMN = 3'd6
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // input transfer: latch byte, pick width
    logic div_step;  // one remainder step of column mod width
    logic out_xfer;  // output transfer: advance column, count down
  } te_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tab;    // byte on the input port is a tab
    logic need_div;  // tab pads to next multiple (no start column)
    logic div_last;  // final remainder step this cycle
    logic run_last;  // byte in the output register ends its run
  } te_sts_t;

  function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
    logic [WIDTH_BITS-1:0] r;
    if (w == '0) begin
      r = 7'd1;
    end else if (w > WIDTH_CAP) begin
      r = WIDTH_CAP;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tab_expander.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_char[7:0]
// out     | output    | out_valid/out_stall | out_char[7:0], out_last_of_run
// cfg     | input     | cfg_we              | cfg_index[2:0], cfg_data[11:0]
//
// One byte is worked on at a time. A plain byte takes the input transfer,
// then one output transfer. A tab with start_column set gives its run of
// 1..64 spaces right after the transfer. A tab that pads to a tab stop
// first runs the column mod width unit, one quotient bit per cycle.
// Reset (rst_n low, synchronous) clears column, list index and the
// registers to their defaults. out_stall holds the current output byte
// and the whole run; in_stall stays high from the input transfer until
// the last byte of its run has been taken.

module tab_expander
  import te_pkg::*;
#(
  parameter int unsigned MAX_STOPS     = 4,
  parameter int unsigned DEFAULT_WIDTH = 8,
  parameter int unsigned COLUMN_BITS   = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_char,
  output logic                     out_last_of_run,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  te_cmd_t cmd;
  te_sts_t sts;

  // Sequencer: accept, optional remainder pass, then the output run.
  te_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Registers, column tracking, width pick, mod unit and output register.
  te_dp #(
    .MAX_STOPS     (MAX_STOPS),
    .DEFAULT_WIDTH (DEFAULT_WIDTH),
    .COLUMN_BITS   (COLUMN_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char         (in_char),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== hw/rtl/te_ctrl.sv =====
`timescale 1ns / 1ps

`include "tab_expander_macros.svh"

module te_ctrl
  import te_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  te_sts_t sts,
  output te_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.is_tab && sts.need_div) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid    = 1'b1;
        cmd.out_xfer = !out_stall;
        if (!out_stall && sts.run_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TE_ASSERT_NEXT(a_div_to_emit, state_r == S_DIV && sts.div_last, state_r == S_EMIT)
  `TE_ASSERT_NEXT(a_run_end_idle, cmd.out_xfer && sts.run_last, state_r == S_IDLE)
  `TE_ASSERT_NEXT(a_plain_byte_emits, cmd.load && !sts.is_tab, state_r == S_EMIT && out_valid)

endmodule

// ===== hw/rtl/te_dp.sv =====
`timescale 1ns / 1ps

`include "tab_expander_macros.svh"

module te_dp
  import te_pkg::*;
#(
  parameter int unsigned MAX_STOPS     = 4,
  parameter int unsigned DEFAULT_WIDTH = 8,
  parameter int unsigned COLUMN_BITS   = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               in_char,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  te_cmd_t                  cmd,
  output te_sts_t                  sts,
  output logic [7:0]               out_char,
  output logic                     out_last_of_run
);

  localparam logic [2:0] LEN_CAP = 3'((MAX_STOPS < 4) ? MAX_STOPS : 4);
  localparam logic [WIDTH_BITS-1:0] DEF_W =
    WIDTH_BITS'((DEFAULT_WIDTH < 1) ? 1 : ((DEFAULT_WIDTH > 64) ? 64 : DEFAULT_WIDTH));
  localparam int unsigned CMP_BITS = (COLUMN_BITS > CFG_DATA_BITS) ? COLUMN_BITS : CFG_DATA_BITS;
  localparam int unsigned CNT_BITS = $clog2(COLUMN_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COLUMN_BITS - 1);

  // configuration
  logic [2:0]              stop_count_r;
  logic [WIDTH_BITS-1:0]   stop_w_r [4];
  logic [WIDTH_BITS-1:0]   repeat_w_r;
  logic [CFG_DATA_BITS-1:0] start_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      stop_w_r[0]  <= 7'd8;
      stop_w_r[1]  <= 7'd8;
      stop_w_r[2]  <= 7'd8;
      stop_w_r[3]  <= 7'd8;
      repeat_w_r   <= '0;
      start_col_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STOP_COUNT:   stop_count_r <= cfg_data[2:0];
        REG_STOP_WIDTH_A: stop_w_r[0]  <= cfg_data[WIDTH_BITS-1:0];
        REG_STOP_WIDTH_B: stop_w_r[1]  <= cfg_data[WIDTH_BITS-1:0];
        REG_STOP_WIDTH_C: stop_w_r[2]  <= cfg_data[WIDTH_BITS-1:0];
        REG_STOP_WIDTH_D: stop_w_r[3]  <= cfg_data[WIDTH_BITS-1:0];
        REG_REPEAT_WIDTH: repeat_w_r   <= cfg_data[WIDTH_BITS-1:0];
        REG_START_COLUMN: start_col_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // line state
  logic [COLUMN_BITS-1:0] column_r, column_nxt;
  logic [2:0]             list_idx_r, list_idx_nxt;
  // item state
  logic [7:0]             char_r;
  logic [WIDTH_BITS-1:0]  width_r;
  logic [WIDTH_BITS-1:0]  remain_r, remain_nxt;
  logic [WIDTH_BITS-1:0]  rem_r;
  logic [COLUMN_BITS-1:0] dvd_r;
  logic [CNT_BITS-1:0]    cnt_r;

  logic [2:0]            list_len;
  logic                  in_list;
  logic [WIDTH_BITS-1:0] width_sel;
  logic                  past_start;
  logic [WIDTH_BITS:0]   rem_sh;
  logic [WIDTH_BITS-1:0] rem_step;

  always_comb begin
    list_len = (stop_count_r > LEN_CAP) ? LEN_CAP : stop_count_r;
    in_list  = list_idx_r < list_len;
    if (in_list) begin
      width_sel = clamp_width(stop_w_r[list_idx_r[1:0]]);
    end else if (repeat_w_r != '0) begin
      width_sel = clamp_width(repeat_w_r);
    end else if (list_len != '0) begin
      width_sel = 7'd1;
    end else begin
      width_sel = DEF_W;
    end
    past_start = CMP_BITS'(column_r) >= CMP_BITS'(start_col_r);
  end

  // one restoring step: remainder stays below width, so the difference fits
  always_comb begin
    rem_sh = {rem_r, dvd_r[COLUMN_BITS-1]};
    if (rem_sh >= {1'b0, width_r}) begin
      rem_step = WIDTH_BITS'(rem_sh - {1'b0, width_r});
    end else begin
      rem_step = rem_sh[WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    column_nxt   = column_r;
    list_idx_nxt = list_idx_r;
    remain_nxt   = remain_r;
    if (cmd.load) begin
      if (in_char != CH_TAB) begin
        remain_nxt = 7'd1;
      end else begin
        if (in_list) begin
          list_idx_nxt = list_idx_r + 3'd1;
        end
        if (start_col_r != '0) begin
          remain_nxt = past_start ? width_sel : 7'd1;
        end
      end
    end
    if (cmd.div_step && sts.div_last) begin
      remain_nxt = width_r - rem_step;
    end
    if (cmd.out_xfer) begin
      remain_nxt = remain_r - 7'd1;
      if (char_r == CH_NL) begin
        column_nxt   = '0;
        list_idx_nxt = '0;
      end else if (column_r != '1) begin
        column_nxt = column_r + COLUMN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      list_idx_r <= '0;
      remain_r   <= '0;
    end else begin
      column_r   <= column_nxt;
      list_idx_r <= list_idx_nxt;
      remain_r   <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r  <= (in_char == CH_TAB) ? CH_SPACE : in_char;
      width_r <= width_sel;
      rem_r   <= '0;
      dvd_r   <= column_r;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[COLUMN_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
  end

  assign sts.is_tab   = in_char == CH_TAB;
  assign sts.need_div = start_col_r == '0;
  assign sts.div_last = cnt_r == CNT_LAST;
  assign sts.run_last = remain_r == 7'd1;

  assign out_char        = char_r;
  assign out_last_of_run = sts.run_last;

  `TE_ASSERT_NEXT(a_run_len_range, cmd.div_step && sts.div_last,
                  remain_r != '0 && remain_r <= WIDTH_CAP)
  `TE_ASSERT_NEXT(a_newline_clears, cmd.out_xfer && char_r == CH_NL,
                  column_r == '0 && list_idx_r == '0)
  `TE_ASSERT_NOW(a_remainder_below_width, cmd.div_step, rem_r < width_r)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import te_pkg::*;

  // Block configuration as instantiated (defaults of the top level).
  localparam int unsigned NUM_STOPS   = 4;
  localparam int unsigned PLAIN_WIDTH = 8;
  localparam logic [11:0] COL_TOP     = 12'hFFF;

  // Hold-off before a register write, the final quiet window and the watchdog.
  localparam int unsigned QUIET_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_char = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               out_char;
  logic                     out_last_of_run;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Text bytes waiting for the driver, and the bytes the block owes us.
  logic [7:0] text_q[$];
  out_byte_t  out_due_q[$];
  out_byte_t  head;

  // Shadow of the block: line position, list walker and register file.
  logic [11:0] col = '0;
  logic [2:0]  tab_idx = '0;
  logic [2:0]  stop_cnt = '0;
  logic [6:0]  stop_w[4] = '{7'd8, 7'd8, 7'd8, 7'd8};
  logic [6:0]  rep_w = '0;
  logic [11:0] start_col = '0;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  logic        in_fire = 1'b0;

  tab_expander u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advance the column by one byte, sticking at the top of its range.
  task automatic step_column();
    if (col != COL_TOP) begin
      col = col + 12'd1;
    end
  endtask

  // Work out the bytes one input byte turns into and queue them.
  task automatic expand_byte(input logic [7:0] c);
    int unsigned stops;
    int unsigned w;
    int unsigned run;
    out_byte_t   ob;
    if (c != CH_TAB) begin
      ob.ch = c;
      ob.last = 1'b1;
      out_due_q.push_back(ob);
      step_column();
      // A newline still counts as a byte, then restarts the line.
      if (c == CH_NL) begin
        col = '0;
        tab_idx = '0;
      end
      return;
    end
    // List length is clamped to the number of width registers.
    stops = (stop_cnt > NUM_STOPS) ? NUM_STOPS : stop_cnt;
    if (tab_idx < stops) begin
      w = 32'(stop_w[tab_idx[1:0]]);
      tab_idx = tab_idx + 3'd1;
    end else if (rep_w != '0) begin
      w = 32'(rep_w);
    end else if (stops != 0) begin
      w = 1;
    end else begin
      w = PLAIN_WIDTH;
    end
    // Zero width acts as one; anything past the cap is cut to it.
    if (w == 0) begin
      w = 1;
    end else if (w > WIDTH_CAP) begin
      w = WIDTH_CAP;
    end
    if (start_col != '0) begin
      run = (col >= start_col) ? w : 1;
    end else begin
      run = w - (col % w);
    end
    for (int unsigned i = 0; i < run; i++) begin
      ob.ch = CH_SPACE;
      ob.last = (i + 1 == run);
      out_due_q.push_back(ob);
      step_column();
    end
  endtask

  // Driver: present the next text byte once the previous one transferred.
  // Valid is decided without looking at stall; a held byte never changes.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (rst_n && text_q.size() != 0 && $urandom_range(99) >= send_pct) begin
        in_valid <= 1'b1;
        in_char <= text_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Monitor: predict on every input transfer, check every output transfer.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expand_byte(in_char);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (out_due_q.size() == 0) begin
          flag_error($sformatf("output byte 0x%02h with nothing owed", out_char));
        end else begin
          head = out_due_q.pop_front();
          if (out_char !== head.ch) begin
            flag_error($sformatf("out_char 0x%02h, want 0x%02h", out_char, head.ch));
          end
          if (out_last_of_run !== head.last) begin
            flag_error($sformatf("out_last_of_run %b, want %b (byte 0x%02h)",
                                 out_last_of_run, head.last, head.ch));
          end
        end
      end
    end
  end

  // Write one register while the block is idle and mirror it in the shadow.
  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STOP_COUNT: begin
        stop_cnt = val[2:0];
      end
      REG_STOP_WIDTH_A: begin
        stop_w[0] = val[6:0];
      end
      REG_STOP_WIDTH_B: begin
        stop_w[1] = val[6:0];
      end
      REG_STOP_WIDTH_C: begin
        stop_w[2] = val[6:0];
      end
      REG_STOP_WIDTH_D: begin
        stop_w[3] = val[6:0];
      end
      REG_REPEAT_WIDTH: begin
        rep_w = val[6:0];
      end
      REG_START_COLUMN: begin
        start_col = val;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_text(input logic [7:0] c);
    text_q.push_back(c);
    items_queued++;
  endtask

  // Wait until every byte went in and every owed byte came out, then hold off.
  task automatic drain();
    while (items_taken != items_queued || out_due_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Mostly tabs and printable text, some newlines, some arbitrary bytes.
  function automatic logic [7:0] random_text();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 35) begin
      b = CH_TAB;
    end else if (r < 45) begin
      b = CH_NL;
    end else if (r < 85) begin
      b = 8'($urandom_range(126, 32));
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  // Favor the edges of the width range; keep the rest small so runs stay short.
  function automatic logic [11:0] random_width();
    logic [11:0] w;
    case ($urandom_range(5))
      0: w = 12'd0;
      1: w = 12'd1;
      2: w = 12'd64;
      3: w = 12'd127;
      default: w = 12'($urandom_range(24, 1));
    endcase
    return w;
  endfunction

  task automatic random_setup();
    logic [11:0] sc;
    write_reg(REG_STOP_COUNT, 12'($urandom_range(7)));
    write_reg(REG_STOP_WIDTH_A, random_width());
    write_reg(REG_STOP_WIDTH_B, random_width());
    write_reg(REG_STOP_WIDTH_C, random_width());
    write_reg(REG_STOP_WIDTH_D, random_width());
    write_reg(REG_REPEAT_WIDTH, ($urandom_range(2) == 0) ? 12'd0 : random_width());
    case ($urandom_range(5))
      0: sc = 12'd1;
      1: sc = 12'd4095;
      2: sc = 12'($urandom_range(4095));
      3: sc = 12'($urandom_range(40, 1));
      default: sc = 12'd0;
    endcase
    write_reg(REG_START_COLUMN, sc);
  endtask

  initial begin
    // Sender idles often, receiver very often, for the first stretch.
    send_pct = 36;
    recv_pct = 81;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: no list, no repeat width, so tabs pad to multiples of 8.
    // Cover both values of every data bit and tabs landing on a stop.
    push_text(8'h41);
    push_text(CH_TAB);
    push_text(8'h00);
    push_text(8'hFF);
    push_text(CH_TAB);
    push_text(CH_TAB);
    push_text(CH_NL);
    push_text(CH_TAB);
    push_text(CH_NL);
    drain();

    // Overlong list (clamped to four), zero and oversized widths, then the
    // list runs out with no repeat width, so each later tab is one space.
    write_reg(REG_STOP_COUNT, 12'd7);
    write_reg(REG_STOP_WIDTH_A, 12'd0);
    write_reg(REG_STOP_WIDTH_B, 12'd127);
    write_reg(REG_STOP_WIDTH_C, 12'd1);
    write_reg(REG_STOP_WIDTH_D, 12'd64);
    write_reg(REG_REPEAT_WIDTH, 12'd0);
    write_reg(REG_START_COLUMN, 12'd0);
    repeat (5) push_text(CH_TAB);
    push_text(8'h78);
    push_text(CH_NL);
    drain();

    // Start column mode: one space before column 3, full width from it on.
    // The list then hands over to a clamped repeat width; a newline restarts it.
    write_reg(REG_STOP_COUNT, 12'd1);
    write_reg(REG_STOP_WIDTH_A, 12'd5);
    write_reg(REG_REPEAT_WIDTH, 12'd127);
    write_reg(REG_START_COLUMN, 12'd3);
    push_text(CH_TAB);
    push_text(8'h61);
    push_text(8'h62);
    push_text(CH_TAB);
    push_text(CH_NL);
    push_text(CH_TAB);
    drain();

    for (int p = 0; p < 11; p++) begin
      // Swap the idle pressure after four phases, drop it after eight.
      if (p == 4) begin
        send_pct = 81;
        recv_pct = 36;
      end else if (p == 8) begin
        send_pct = 0;
        recv_pct = 0;
      end
      if (p == 2) begin
        // Everything at its top value.
        write_reg(REG_STOP_COUNT, 12'd7);
        write_reg(REG_STOP_WIDTH_A, 12'd127);
        write_reg(REG_STOP_WIDTH_B, 12'd127);
        write_reg(REG_STOP_WIDTH_C, 12'd127);
        write_reg(REG_STOP_WIDTH_D, 12'd127);
        write_reg(REG_REPEAT_WIDTH, 12'd127);
        write_reg(REG_START_COLUMN, 12'd4095);
      end else if (p == 5) begin
        // Full list of zero widths, no repeat width, earliest start column.
        write_reg(REG_STOP_COUNT, 12'd4);
        write_reg(REG_STOP_WIDTH_A, 12'd0);
        write_reg(REG_STOP_WIDTH_B, 12'd0);
        write_reg(REG_STOP_WIDTH_C, 12'd0);
        write_reg(REG_STOP_WIDTH_D, 12'd0);
        write_reg(REG_REPEAT_WIDTH, 12'd0);
        write_reg(REG_START_COLUMN, 12'd1);
      end else begin
        random_setup();
      end
      repeat (30) push_text(random_text());
      drain();

      if (p == 1) begin
        // Run one line past the end of the column range: 64-wide stops from
        // column 0, so 64 tabs reach the top and the column sticks there.
        write_reg(REG_STOP_COUNT, 12'd0);
        write_reg(REG_REPEAT_WIDTH, 12'd64);
        write_reg(REG_START_COLUMN, 12'd0);
        push_text(CH_NL);
        repeat (66) push_text(CH_TAB);
        push_text(8'h7A);
        push_text(CH_TAB);
        drain();
        // Column still stuck at its top; the highest start column is met.
        write_reg(REG_START_COLUMN, 12'd4095);
        push_text(CH_TAB);
        push_text(8'h71);
        push_text(CH_TAB);
        push_text(CH_NL);
        drain();
      end
    end

    // Let any stray output show up before calling it.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
